@@ sv/rpr_pkg.sv @@
package rpr_pkg;

   localparam int PSUM_FIELD_W = 32;
   localparam int RADDR_FIELD_W = 9;
   localparam int WADDR_FIELD_W = 14;
   localparam int FEAT_W = 8;
   localparam int COEF_W = 32;
   localparam int OFFSET_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int PROD_W = PSUM_FIELD_W + COEF_W;

   localparam int MODE_ENABLE_BIT = 0;
   localparam int MODE_RELU_BIT = 1;
   localparam int MODE_MAX_BIT = 2;

   localparam logic signed [FEAT_W-1:0] FEAT_MAX = 8'sd127;
   localparam logic signed [FEAT_W-1:0] FEAT_MIN = -8'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_KERNEL_EXTENT,
      CSR_WINDOW_SETUP,
      CSR_READ_SETUP,
      CSR_WRITE_BASE,
      CSR_WRITE_ENDS,
      CSR_WRITE_STEPS,
      CSR_SCALE_MULT
   } csr_index_type;

   typedef struct packed {
      logic [2:0]               mode;
      logic [15:0]              kernel_extent;
      logic [23:0]              window_setup;
      logic [24:0]              read_setup;
      logic [13:0]              write_base;
      logic [31:0]              write_ends;
      logic [47:0]              write_steps;
      logic signed [COEF_W-1:0] scale_mult;
   } cfg_type;

   typedef struct packed {
      logic signed [PSUM_FIELD_W-1:0] psum_value;
      logic                           start_req;
   } req_payload_type;

   typedef struct packed {
      logic [RADDR_FIELD_W-1:0] read_address;
      logic                     write_valid;
      logic [WADDR_FIELD_W-1:0] write_address;
      logic signed [FEAT_W-1:0] feature_value;
   } rsp_payload_type;

   typedef struct packed {
      logic [RADDR_FIELD_W-1:0]       read_address;
      logic                           write_valid;
      logic [WADDR_FIELD_W-1:0]       write_address;
      logic signed [PSUM_FIELD_W-1:0] pooled;
   } pool_beat_type;

endpackage

@@ sv/rpr_stream_if.sv @@
interface rpr_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/rpr_walker.sv @@
module rpr_walker #(
   parameter int PSUM_WIDTH = 32,
   parameter int READ_DEPTH = 512,
   parameter int WRITE_DEPTH = 16384,
   parameter int COUNTER_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rpr_pkg::cfg_type      cfg,
   rpr_stream_if.sink            req_chan,
   output logic                  pool_valid,
   output rpr_pkg::pool_beat_type pool_beat,
   input  logic                  pool_ready
);
   import rpr_pkg::*;

   localparam int CW = COUNTER_WIDTH;
   localparam int RA_W = $clog2(READ_DEPTH);
   localparam int WA_W = $clog2(WRITE_DEPTH);

   logic [CW-1:0] kc_ff, kr_ff, wc_ff, wr_ff;
   logic [CW-1:0] kc_in, kr_in, wc_in, wr_in;
   logic [CW-1:0] kc, kr, wc, wr;
   logic [OFFSET_W-1:0] off1_ff, off2_ff, off3_ff;
   logic [OFFSET_W-1:0] off1_in, off2_in, off3_in;
   logic [OFFSET_W-1:0] off1, off2, off3;
   logic signed [PSUM_WIDTH-1:0] acc_ff, acc_in;
   logic signed [PSUM_WIDTH-1:0] v;
   logic [CW-1:0] last_kc, last_kr, last_wc, stride_c, stride_r;
   logic [CW:0] row_sum, col_sum;
   logic [RA_W-1:0] row_prod, raddr;
   logic [WA_W-1:0] waddr;
   logic take, start, closed, first;
   logic pool_valid_ff;
   pool_beat_type beat_ff, beat_in;

   assign req_chan.ready = !pool_valid_ff || pool_ready;
   assign take = req_chan.valid && req_chan.ready && cfg.mode[MODE_ENABLE_BIT];
   assign start = req_chan.payload.start_req;

   // a start beat sees cleared counters and offsets
   assign kc = start ? '0 : kc_ff;
   assign kr = start ? '0 : kr_ff;
   assign wc = start ? '0 : wc_ff;
   assign wr = start ? '0 : wr_ff;
   assign off1 = start ? '0 : off1_ff;
   assign off2 = start ? '0 : off2_ff;
   assign off3 = start ? '0 : off3_ff;

   assign last_kc = CW'(cfg.kernel_extent[7:0]);
   assign last_kr = CW'(cfg.kernel_extent[15:8]);
   assign last_wc = CW'(cfg.window_setup[7:0]);
   assign stride_c = CW'(cfg.window_setup[15:8]);
   assign stride_r = CW'(cfg.window_setup[23:16]);

   // read address only matters modulo the buffer depth
   assign row_sum = {1'b0, wr} + {1'b0, kr};
   assign col_sum = {1'b0, wc} + {1'b0, kc};
   assign row_prod = RA_W'(RA_W'(row_sum) * RA_W'(cfg.read_setup[24:9]));
   assign raddr = RA_W'(cfg.read_setup[8:0]) + row_prod + RA_W'(col_sum);

   assign waddr = WA_W'(cfg.write_base) + WA_W'(off1) + WA_W'(off2) + WA_W'(off3);

   assign first = (kc == '0) && (kr == '0);
   assign closed = (kc == last_kc) && (kr == last_kr);

   always_comb begin
      v = req_chan.payload.psum_value[PSUM_WIDTH-1:0];
      if (cfg.mode[MODE_RELU_BIT] && v[PSUM_WIDTH-1]) begin
         v = '0;
      end
      if (first) begin
         acc_in = v;
      end else if (cfg.mode[MODE_MAX_BIT]) begin
         acc_in = (v > acc_ff) ? v : acc_ff;
      end else begin
         acc_in = acc_ff + v;
      end
   end

   always_comb begin
      off1_in = off1;
      off2_in = off2;
      off3_in = off3;
      if (closed) begin
         if (off1 == cfg.write_ends[15:0]) begin
            if (off2 == cfg.write_ends[31:16]) begin
               off2_in = '0;
               off3_in = off3 + cfg.write_steps[47:32];
            end else begin
               off2_in = off2 + cfg.write_steps[31:16];
            end
         end else begin
            off1_in = off1 + cfg.write_steps[15:0];
         end
      end
   end

   always_comb begin
      kc_in = kc;
      kr_in = kr;
      wc_in = wc;
      wr_in = wr;
      if (kc == last_kc) begin
         kc_in = '0;
         if (kr == last_kr) begin
            kr_in = '0;
            if (wc == last_wc) begin
               wc_in = '0;
               wr_in = wr + stride_r;
            end else begin
               wc_in = wc + stride_c;
            end
         end else begin
            kr_in = kr + 1'b1;
         end
      end else begin
         kc_in = kc + 1'b1;
      end
   end

   always_comb begin
      beat_in.read_address = RADDR_FIELD_W'(raddr);
      beat_in.write_valid = closed;
      beat_in.write_address = closed ? WADDR_FIELD_W'(waddr) : '0;
      beat_in.pooled = PSUM_FIELD_W'(acc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff <= '0;
         kr_ff <= '0;
         wc_ff <= '0;
         wr_ff <= '0;
         off1_ff <= '0;
         off2_ff <= '0;
         off3_ff <= '0;
         pool_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            kc_ff <= kc_in;
            kr_ff <= kr_in;
            wc_ff <= wc_in;
            wr_ff <= wr_in;
            off1_ff <= off1_in;
            off2_ff <= off2_in;
            off3_ff <= off3_in;
         end
         if (req_chan.ready) begin
            pool_valid_ff <= take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         acc_ff <= acc_in;
         beat_ff <= beat_in;
      end
   end

   assign pool_valid = pool_valid_ff;
   assign pool_beat = beat_ff;
endmodule

@@ sv/rpr_requant.sv @@
module rpr_requant (
   input  logic                   clock,
   input  logic                   reset,
   input  rpr_pkg::cfg_type       cfg,
   input  logic                   pool_valid,
   input  rpr_pkg::pool_beat_type pool_beat,
   output logic                   pool_ready,
   rpr_stream_if.source           rsp_chan
);
   import rpr_pkg::*;

   logic prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   pool_beat_type meta_ff;
   logic signed [COEF_W-1:0] prod_hi;
   logic signed [FEAT_W-1:0] sat;
   logic out_adv;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   assign out_adv = !rsp_valid_ff || rsp_chan.ready;
   assign pool_ready = !prod_valid_ff || out_adv;

   assign prod_in = pool_beat.pooled * cfg.scale_mult;

   // floor shift by 32 is the top half of the product
   assign prod_hi = prod_ff[PROD_W-1:PROD_W-COEF_W];

   always_comb begin
      if (prod_hi > COEF_W'(FEAT_MAX)) begin
         sat = FEAT_MAX;
      end else if (prod_hi < COEF_W'(FEAT_MIN)) begin
         sat = FEAT_MIN;
      end else begin
         sat = FEAT_W'(prod_hi);
      end
      rsp_in.read_address = meta_ff.read_address;
      rsp_in.write_valid = meta_ff.write_valid;
      rsp_in.write_address = meta_ff.write_address;
      rsp_in.feature_value = meta_ff.write_valid ? sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pool_ready) begin
            prod_valid_ff <= pool_valid;
         end
         if (out_adv) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pool_ready && pool_valid) begin
         prod_ff <= prod_in;
         meta_ff <= pool_beat;
      end
      if (out_adv && prod_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule

@@ sv/relu_pool_requantize_top.sv @@
// path: a req beat goes through the pooling, product and output registers to its rsp beat
// one beat per cycle unless rsp stalls; counters, offsets and pooling register step per beat
// stages: window walk and pooling, 32x32 product register, int8 saturation output register
// a req beat taken while mode enable is clear gives no rsp beat and leaves all state alone
// reset: synchronous, clears configuration, counters, write offsets and all valid flags
// read and write buffer depths are powers of two
module relu_pool_requantize_top #(
   parameter int PSUM_WIDTH = 32,
   parameter int READ_DEPTH = 512,
   parameter int WRITE_DEPTH = 16384,
   parameter int COUNTER_WIDTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   rpr_stream_if.sink                       req_chan,
   rpr_stream_if.source                     rsp_chan,
   input  logic                             csr_write_en,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rpr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic pool_valid, pool_ready;
   pool_beat_type pool_beat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:          cfg_in.mode = csr_wdata[2:0];
            CSR_KERNEL_EXTENT: cfg_in.kernel_extent = csr_wdata[15:0];
            CSR_WINDOW_SETUP:  cfg_in.window_setup = csr_wdata[23:0];
            CSR_READ_SETUP:    cfg_in.read_setup = csr_wdata[24:0];
            CSR_WRITE_BASE:    cfg_in.write_base = csr_wdata[13:0];
            CSR_WRITE_ENDS:    cfg_in.write_ends = csr_wdata[31:0];
            CSR_WRITE_STEPS:   cfg_in.write_steps = csr_wdata[47:0];
            CSR_SCALE_MULT:    cfg_in.scale_mult = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpr_walker #(
      .PSUM_WIDTH    (PSUM_WIDTH),
      .READ_DEPTH    (READ_DEPTH),
      .WRITE_DEPTH   (WRITE_DEPTH),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .pool_valid (pool_valid),
      .pool_beat  (pool_beat),
      .pool_ready (pool_ready)
   );

   rpr_requant u_requant (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pool_valid (pool_valid),
      .pool_beat  (pool_beat),
      .pool_ready (pool_ready),
      .rsp_chan   (rsp_chan)
   );

   // a beat without a closed window carries zero write address and value
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.write_valid |->
         rsp_chan.payload.write_address == '0 && rsp_chan.payload.feature_value == '0)
      else $error("open window beat carries nonzero write data");

   // an empty output register means no pipeline stage may hold back a req beat
   assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("req stalled while rsp side is free");

   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("rsp valid after reset");
endmodule
